// ===== rtl/lrt_pkg.sv =====
// Shared constants and types for the line run thinning block.
package lrt_pkg;

    // Line size default and configuration widths
    localparam int MAX_LINE_DEF = 4096;
    localparam int RADIUS_W     = 11;
    localparam int CFG_LEN_W    = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd1;

    // Reset values of the registers
    localparam logic [RADIUS_W-1:0]  RADIUS_RST   = 11'd1;
    localparam logic [CFG_LEN_W-1:0] LINE_LEN_RST = 13'd4096;

    // Depth of the run queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/line_run_thinning.sv =====
// A run's descriptor enters the run queue when the pixel that closes it is taken, then the output register.
// Throughput: one pixel per cycle while the run queue is not full; the two-entry run queue and the output register
// let the pixel side keep going while a result beat waits to be taken.
// Reset: synchronous active-low i_rst_n clears line position, open run, queue and
// output valid; the trim radius returns to 1 and line_length to 4096.
// Top level of the line run thinning block.
module line_run_thinning
    import lrt_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF,
    parameter int POS_W    = $clog2(MAX_LINE),
    parameter int SIZE_W   = POS_W + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_pixel,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [POS_W-1:0]      o_run_begin,
    output logic [SIZE_W-1:0]     o_run_size,
    output logic [POS_W-1:0]      o_kept_begin,
    output logic [SIZE_W-1:0]     o_kept_size,
    output logic                  o_line_done
);

    localparam int REC_W = POS_W + SIZE_W + 1;

    logic [RADIUS_W-1:0]  r_trim_radius;
    logic [CFG_LEN_W-1:0] r_line_length;

    logic             push;
    logic             pop;
    logic [REC_W-1:0] push_rec;
    logic [REC_W-1:0] head_rec;
    t_q_stat          q_stat;

    // Take configuration beats whenever out of reset
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim_radius <= RADIUS_RST;
            r_line_length <= LINE_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TRIM_RADIUS: r_trim_radius <= i_cfg_data[RADIUS_W-1:0];
                REG_LINE_LENGTH: r_line_length <= i_cfg_data[CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    lrt_front #(
        .MAX_LINE (MAX_LINE),
        .POS_W    (POS_W),
        .SIZE_W   (SIZE_W),
        .REC_W    (REC_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (i_pixel),
        .i_line_length (r_line_length),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    lrt_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_rec),
        .i_pop   (pop),
        .o_data  (head_rec),
        .o_stat  (q_stat)
    );

    lrt_back #(
        .MAX_LINE (MAX_LINE),
        .POS_W    (POS_W),
        .SIZE_W   (SIZE_W),
        .REC_W    (REC_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_trim_radius (r_trim_radius),
        .i_q_stat      (q_stat),
        .i_rec         (head_rec),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_run_begin   (o_run_begin),
        .o_run_size    (o_run_size),
        .o_kept_begin  (o_kept_begin),
        .o_kept_size   (o_kept_size),
        .o_line_done   (o_line_done)
    );

endmodule

// ===== rtl/lrt_front.sv =====
// Front end: tracks line position and open run, classifies each pixel.
module lrt_front
    import lrt_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF,
    parameter int POS_W    = $clog2(MAX_LINE),
    parameter int SIZE_W   = POS_W + 1,
    parameter int REC_W    = POS_W + SIZE_W + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_pixel,
    input  logic [CFG_LEN_W-1:0] i_line_length,
    input  t_q_stat              i_q_stat,
    output logic                 o_push,
    output logic [REC_W-1:0]     o_rec
);

    localparam int LEN_W = (SIZE_W > CFG_LEN_W) ? SIZE_W : CFG_LEN_W;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_open_begin, n_open_begin;
    logic             r_in_run, n_in_run;

    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  len_ext;
    logic              last;
    logic              accept;
    logic [POS_W-1:0]  rec_begin;
    logic [SIZE_W-1:0] rec_size;
    logic              emit;

    // Clamp the line length into one to MAX_LINE
    assign len_ext = LEN_W'(i_line_length);
    always_comb begin
        if (len_ext == '0) begin
            eff_len = LEN_W'(1);
        end else if (len_ext > LEN_W'(MAX_LINE)) begin
            eff_len = LEN_W'(MAX_LINE);
        end else begin
            eff_len = len_ext;
        end
    end

    // Hold off pixels during reset and while the queue is full
    assign last    = (LEN_W'(r_pos) + LEN_W'(1)) >= eff_len;
    assign o_ready = i_rst_n && !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    // Classify the pixel: close a run, end the line, or nothing
    always_comb begin
        rec_begin = r_in_run ? r_open_begin : r_pos;
        rec_size  = SIZE_W'(r_pos) + SIZE_W'(i_pixel && last) - SIZE_W'(rec_begin);
        emit      = 1'b0;
        if (i_pixel) begin
            emit = last;
        end else if (r_in_run) begin
            emit = 1'b1;
        end else begin
            emit      = last;
            rec_begin = '0;
            rec_size  = '0;
        end
    end

    assign o_push = accept && emit;
    assign o_rec  = {last, rec_size, rec_begin};

    // Advance position and run state
    always_comb begin
        n_pos        = r_pos;
        n_open_begin = r_open_begin;
        n_in_run     = r_in_run;
        if (accept) begin
            if (last) begin
                n_pos        = '0;
                n_open_begin = '0;
                n_in_run     = 1'b0;
            end else begin
                n_pos = r_pos + POS_W'(1);
                if (i_pixel && !r_in_run) begin
                    n_open_begin = r_pos;
                end
                n_in_run = i_pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_open_begin <= '0;
            r_in_run     <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_open_begin <= n_open_begin;
            r_in_run     <= n_in_run;
        end
    end

endmodule

// ===== rtl/lrt_queue.sv =====
// Short run queue that decouples the front from the back.
module lrt_queue
    import lrt_pkg::*;
#(
    parameter int WIDTH = 26,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed record
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/lrt_back.sv =====
// Back end: works out the kept span of a run and holds the result beat.
module lrt_back
    import lrt_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF,
    parameter int POS_W    = $clog2(MAX_LINE),
    parameter int SIZE_W   = POS_W + 1,
    parameter int REC_W    = POS_W + SIZE_W + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [RADIUS_W-1:0] i_trim_radius,
    input  t_q_stat             i_q_stat,
    input  logic [REC_W-1:0]    i_rec,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [POS_W-1:0]    o_run_begin,
    output logic [SIZE_W-1:0]   o_run_size,
    output logic [POS_W-1:0]    o_kept_begin,
    output logic [SIZE_W-1:0]   o_kept_size,
    output logic                o_line_done
);

    localparam int CW = (SIZE_W > RADIUS_W + 1) ? SIZE_W : RADIUS_W + 1;

    logic              r_valid;
    logic [POS_W-1:0]  r_run_begin;
    logic [SIZE_W-1:0] r_run_size;
    logic [POS_W-1:0]  r_kept_begin;
    logic [SIZE_W-1:0] r_kept_size;
    logic              r_line_done;

    logic [POS_W-1:0]  rec_begin;
    logic [SIZE_W-1:0] rec_size;
    logic              rec_last;
    logic [CW-1:0]     size_ext;
    logic [CW-1:0]     twice;
    logic              short_run;
    logic [POS_W-1:0]  kept_begin;
    logic [SIZE_W-1:0] kept_size;

    assign {rec_last, rec_size, rec_begin} = i_rec;

    // Short runs keep the middle pixel, long runs lose radius at each end
    assign size_ext  = CW'(rec_size);
    assign twice     = CW'({i_trim_radius, 1'b0});
    assign short_run = (size_ext <= twice);

    always_comb begin
        if (rec_size == '0) begin
            kept_begin = '0;
            kept_size  = '0;
        end else if (short_run) begin
            kept_begin = rec_begin + POS_W'(rec_size >> 1);
            kept_size  = SIZE_W'(1);
        end else begin
            kept_begin = POS_W'(CW'(rec_begin) + CW'(i_trim_radius));
            kept_size  = SIZE_W'(size_ext - twice);
        end
    end

    assign o_pop = !i_q_stat.empty && (!r_valid || i_ready);

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run_begin  <= rec_begin;
            r_run_size   <= rec_size;
            r_kept_begin <= kept_begin;
            r_kept_size  <= kept_size;
            r_line_done  <= rec_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_run_begin  = r_run_begin;
    assign o_run_size   = r_run_size;
    assign o_kept_begin = r_kept_begin;
    assign o_kept_size  = r_kept_size;
    assign o_line_done  = r_line_done;

endmodule
